/* hw/rtl/wpsp_pkg.sv */
// Shared constants, widths and register codes for the world point to screen projection.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package wpsp_pkg;

    // Viewport size in pixels
    localparam int SCREEN_W = 1280;
    localparam int SCREEN_H = 720;
    localparam int HALF_X   = SCREEN_W / 2;
    localparam int HALF_Y   = SCREEN_H / 2;

    // Field and register widths
    localparam int COORD_W    = 32;
    localparam int ENT_W      = 16;
    localparam int ROW_W      = 48;
    localparam int SCALE_W    = 24;
    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    // Internal datapath widths
    localparam int PROD_W = ENT_W + COORD_W;   // one rotation term
    localparam int SUM_W  = PROD_W + 2;        // three terms
    localparam int FRAC_R = 14;                // Q2.14 rotation fraction
    localparam int VIEW_W = SUM_W - FRAC_R + 1;
    localparam int DEN_W  = VIEW_W;            // positive clip w
    localparam int NUM_W  = VIEW_W + SCALE_W + 1;
    localparam int QB     = 33;                // quotient bits below the clamp check
    localparam int QUOT_W = QB + 1;            // signed clamped quotient
    localparam int PIXP_W = 49;                // viewport product
    localparam int FRAC_N = 16;

    // Pipeline shape
    localparam int DIV_LAT = QB + 2;
    localparam int PRE_ST  = 5;
    localparam int NST     = PRE_ST + DIV_LAT + 1;
    localparam int LAST    = NST - 1;

    // Register reset values
    localparam logic [ROW_W-1:0]   ROT0_RST   = 48'd16384;
    localparam logic [ROW_W-1:0]   ROT1_RST   = 48'd1073741824;
    localparam logic [ROW_W-1:0]   ROT2_RST   = 48'd70368744177664;
    localparam logic [SCALE_W-1:0] XSCALE_RST = 24'd63852;
    localparam logic [SCALE_W-1:0] YSCALE_RST = 24'd113512;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT0   = 8'd0,
        REG_ROT1   = 8'd1,
        REG_ROT2   = 8'd2,
        REG_SHIFTX = 8'd3,
        REG_SHIFTY = 8'd4,
        REG_SHIFTZ = 8'd5,
        REG_XSCALE = 8'd6,
        REG_YSCALE = 8'd7
    } t_reg_idx;

endpackage

/* hw/rtl/world_point_to_screen_projection.sv */
// Top level of the world point to screen projection: view transform, projection divide, viewport map.
// Depends on wpsp_pkg and wpsp_div.
`timescale 1ns / 1ps

// Usage:
// Points enter on i_in_valid / o_in_ready with i_point_x/y/z in Q16.16. Pixel results
// leave on o_out_valid / i_out_ready as o_screen_x, o_screen_y and o_behind_eye.
// The camera is set through the config channel (i_cfg_valid / o_cfg_ready, i_cfg_index,
// i_cfg_data); o_cfg_ready is always high, and an index past the last register is dropped.
// Write the camera only while no point is in flight.
// Throughput: one point per cycle while the receiver keeps up. Most of the pipeline is
// the divider, which resolves one quotient bit per stage for each of the two axes in
// parallel.
// Reset (i_rst_n low at a clock edge) empties the pipeline and loads the camera defaults:
// identity rotation, zero translation, 60 degree field of view.
// When the receiver stalls, the pipeline keeps filling until an item reaches its last
// stage while the output register still holds an untaken result; then everything holds
// and o_in_ready drops. No transfer is lost or repeated.
// A point with clip w at or below zero returns o_behind_eye high and zero pixels.

module world_point_to_screen_projection import wpsp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [COORD_W-1:0]   i_point_x,
    input  logic signed [COORD_W-1:0]   i_point_y,
    input  logic signed [COORD_W-1:0]   i_point_z,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [PIX_W-1:0]     o_screen_x,
    output logic signed [PIX_W-1:0]     o_screen_y,
    output logic                        o_behind_eye,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data
);

    localparam logic signed [PIXP_W-1:0] HALF_XS = PIXP_W'(HALF_X);
    localparam logic signed [PIXP_W-1:0] HALF_YS = PIXP_W'(HALF_Y);
    localparam logic signed [QUOT_W:0]   ONE_N   = (QUOT_W+1)'(65536);
    localparam logic signed [PIXP_W-1:0] RND_N   = PIXP_W'(65535);

    // Camera registers
    logic        [ROW_W-1:0]   r_rot   [0:2];
    logic signed [COORD_W-1:0] r_shift [0:2];
    logic        [SCALE_W-1:0] r_xs;
    logic        [SCALE_W-1:0] r_ys;

    // Pipeline control
    logic r_vld [0:LAST];
    logic r_beh [3:LAST];
    logic r_out_valid;
    logic en;

    // Datapath registers
    logic signed [COORD_W-1:0] r_p    [0:2];
    logic signed [PROD_W-1:0]  r_prod [0:2][0:2];
    logic signed [SUM_W-1:0]   r_sum  [0:2];
    logic signed [VIEW_W-1:0]  r_vx;
    logic signed [VIEW_W-1:0]  r_vy;
    logic        [DEN_W-1:0]   r_den3;
    logic signed [NUM_W-1:0]   r_numx;
    logic signed [NUM_W-1:0]   r_numy;
    logic        [DEN_W-1:0]   r_den4;
    logic signed [PIXP_W-1:0]  r_pxp;
    logic signed [PIXP_W-1:0]  r_pyp;
    logic signed [PIX_W-1:0]   r_sx;
    logic signed [PIX_W-1:0]   r_sy;
    logic                      r_sb;

    logic signed [QUOT_W-1:0]  qx;
    logic signed [QUOT_W-1:0]  qy;
    logic signed [VIEW_W-1:0]  n_v [0:2];
    logic signed [VIEW_W:0]    n_w;
    logic                      load;

    function automatic logic signed [PIX_W-1:0] to_pix(input logic signed [PIXP_W-1:0] p);
        logic signed [PIXP_W-1:0] t;
        logic signed [PIXP_W-FRAC_N-1:0] s;
        t = (p < 0) ? p + RND_N : p;
        s = (PIXP_W-FRAC_N)'(t >>> FRAC_N);
        if (s > (PIXP_W-FRAC_N)'(32767)) begin
            to_pix = 16'sh7fff;
        end else if (s < -(PIXP_W-FRAC_N)'(32768)) begin
            to_pix = -16'sh8000;
        end else begin
            to_pix = PIX_W'(s);
        end
    endfunction

    // Advance unless the last stage holds an item that the output register cannot take
    assign en          = !r_vld[LAST] || !r_out_valid || i_out_ready;
    assign load        = r_vld[LAST] && (!r_out_valid || i_out_ready);
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // Camera register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= ROT0_RST;
            r_rot[1]   <= ROT1_RST;
            r_rot[2]   <= ROT2_RST;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
            r_xs       <= XSCALE_RST;
            r_ys       <= YSCALE_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ROT0:   r_rot[0]   <= i_cfg_data;
                REG_ROT1:   r_rot[1]   <= i_cfg_data;
                REG_ROT2:   r_rot[2]   <= i_cfg_data;
                REG_SHIFTX: r_shift[0] <= i_cfg_data[COORD_W-1:0];
                REG_SHIFTY: r_shift[1] <= i_cfg_data[COORD_W-1:0];
                REG_SHIFTZ: r_shift[2] <= i_cfg_data[COORD_W-1:0];
                REG_XSCALE: r_xs       <= i_cfg_data[SCALE_W-1:0];
                REG_YSCALE: r_ys       <= i_cfg_data[SCALE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Shift valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LAST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s <= LAST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Output register, loaded when empty or while the receiver takes the held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // View coordinates and clip w
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_v[i] = VIEW_W'(r_sum[i] >>> FRAC_R) + VIEW_W'(r_shift[i]);
        end
        n_w = -(VIEW_W+1)'(n_v[2]);
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= i_point_x;
            r_p[1] <= i_point_y;
            r_p[2] <= i_point_z;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[i][k] <= PROD_W'(signed'(r_rot[i][ENT_W*k +: ENT_W]))
                                  * PROD_W'(r_p[k]);
                end
                r_sum[i] <= SUM_W'(r_prod[i][0]) + SUM_W'(r_prod[i][1])
                          + SUM_W'(r_prod[i][2]);
            end
            r_vx     <= n_v[0];
            r_vy     <= n_v[1];
            r_den3   <= n_w[DEN_W-1:0];
            r_beh[3] <= (n_w <= 0);
            r_numx   <= NUM_W'(r_vx) * NUM_W'(signed'({1'b0, r_xs}));
            r_numy   <= NUM_W'(r_vy) * NUM_W'(signed'({1'b0, r_ys}));
            r_den4   <= r_den3;
            for (int s = 4; s <= LAST; s++) begin
                r_beh[s] <= r_beh[s-1];
            end
            r_pxp <= PIXP_W'((QUOT_W+1)'(qx) + ONE_N) * HALF_XS;
            r_pyp <= PIXP_W'((QUOT_W+1)'(qy) + ONE_N) * HALF_YS;
        end
    end

    // Final truncation and saturation into the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sb <= r_beh[LAST];
            r_sx <= r_beh[LAST] ? '0 : to_pix(r_pxp);
            r_sy <= r_beh[LAST] ? '0 : to_pix(r_pyp);
        end
    end

    wpsp_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_numx),
        .i_den  (r_den4),
        .o_quot (qx)
    );

    wpsp_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_numy),
        .i_den  (r_den4),
        .o_quot (qy)
    );

    assign o_out_valid  = r_out_valid;
    assign o_screen_x   = r_sx;
    assign o_screen_y   = r_sy;
    assign o_behind_eye = r_sb;

`ifndef ASSERT_OFF
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_behind_eye |-> (o_screen_x == 0) && (o_screen_y == 0))
        else $error("behind-eye result with nonzero pixels");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] && !en |=> r_vld[LAST])
        else $error("stalled item dropped from last stage");

    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAST] && o_in_ready |=> o_out_valid)
        else $error("item left last stage without reaching output");
`endif

endmodule

/* hw/rtl/wpsp_div.sv */
// Pipelined signed divider, one quotient bit per stage, quotient clamped to +/-2^32.
// Depends on wpsp_pkg for widths and the number of quotient bits.
`timescale 1ns / 1ps

module wpsp_div import wpsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic        [DEN_W-1:0]  i_den,
    output logic signed [QUOT_W-1:0] o_quot
);

    localparam logic [QB-1:0] QLIM = {1'b1, {(QB-1){1'b0}}};

    logic              r_sign [0:QB];
    logic              r_ovf  [0:QB];
    logic [DEN_W-1:0]  r_den  [0:QB];
    logic [DEN_W-1:0]  r_rem  [0:QB];
    logic [QB-1:0]     r_low  [0:QB];
    logic [QB-1:0]     r_q    [0:QB];
    logic signed [QUOT_W-1:0] r_quot;

    logic [DEN_W-1:0]  n_rem  [1:QB];
    logic [QB-1:0]     n_q    [1:QB];
    logic [NUM_W-1:0]  n_mag;
    logic [NUM_W-QB-1:0] n_hi;
    logic [QB-1:0]     n_qmag;

    // Split the magnitude into the part checked for overflow and the bits to divide
    always_comb begin
        n_mag = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        n_hi  = n_mag[NUM_W-1:QB];
    end

    // One restoring step per stage
    always_comb begin
        for (int i = 1; i <= QB; i++) begin
            logic [DEN_W:0] t;
            t = {r_rem[i-1], r_low[i-1][QB-1]};
            if (t >= {1'b0, r_den[i-1]}) begin
                n_rem[i] = DEN_W'(t - {1'b0, r_den[i-1]});
                n_q[i]   = {r_q[i-1][QB-2:0], 1'b1};
            end else begin
                n_rem[i] = DEN_W'(t);
                n_q[i]   = {r_q[i-1][QB-2:0], 1'b0};
            end
        end
    end

    // Clamp the magnitude before the sign goes back on
    always_comb begin
        if (r_ovf[QB] || (r_q[QB] > QLIM)) begin
            n_qmag = QLIM;
        end else begin
            n_qmag = r_q[QB];
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sign[0] <= i_num[NUM_W-1];
            r_ovf[0]  <= NUM_W'(n_hi) >= NUM_W'(i_den);
            r_den[0]  <= i_den;
            r_rem[0]  <= DEN_W'(n_hi);
            r_low[0]  <= n_mag[QB-1:0];
            r_q[0]    <= '0;
            for (int i = 1; i <= QB; i++) begin
                r_sign[i] <= r_sign[i-1];
                r_ovf[i]  <= r_ovf[i-1];
                r_den[i]  <= r_den[i-1];
                r_rem[i]  <= n_rem[i];
                r_low[i]  <= {r_low[i-1][QB-2:0], 1'b0};
                r_q[i]    <= n_q[i];
            end
            r_quot <= r_sign[QB] ? -signed'({1'b0, n_qmag}) : signed'({1'b0, n_qmag});
        end
    end

    assign o_quot = r_quot;

endmodule
